// ===== hdl/ifec_pkg.sv =====
// Shared types and codes of the interrupt flag and enable controller.
package ifec_pkg;

  localparam int unsigned CoreBits = 8;
  localparam int unsigned PeieBit  = 6;
  localparam int unsigned MaxSrc   = 24;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam logic [31:0] CoreMapReset = 32'hFFFF_FFFF;
  localparam logic [7:0]  ByteMask     = 8'hFF;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_RAISE   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_SOFT    = 3'd4
  } kind_e;

  localparam logic [2:0] RegCore = 3'd0;

  localparam logic [CfgIdxW-1:0] CfgCoreMap   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLevelMask = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [4:0] source;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bad_address;
    logic       request_pending;
    logic       interrupt_event;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CfgIdxW-1:0]   index;
    logic [CfgW-1:0]      data;
  } cfg_t;

endpackage

// ===== hdl/ifec_if.sv =====
// Item and result channel interfaces of the interrupt flag and enable controller.
interface ifec_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] reg_select;
  logic [7:0] write_data;
  logic [4:0] source;

  modport source_mp (output valid, kind, reg_select, write_data, source, input ready);
  modport sink_mp (input valid, kind, reg_select, write_data, source, output ready);
endinterface

interface ifec_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       bad_address;
  logic       request_pending;
  logic       interrupt_event;

  modport source_mp (output valid, read_data, bad_address, request_pending,
                     interrupt_event, input ready);
  modport sink_mp (input valid, read_data, bad_address, request_pending,
                   interrupt_event, output ready);
endinterface

// ===== hdl/ifec_core.sv =====
// Register state, configuration and per-item update logic of the controller.
module ifec_core #(
  parameter int unsigned PERIPH_REGS = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ifec_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  ifec_pkg::item_t  item_i,
  output ifec_pkg::result_t result_o
);
  import ifec_pkg::*;

  localparam int unsigned PeriphSrc = CoreBits + 8 * PERIPH_REGS;
  localparam int unsigned NumSrc    = (PeriphSrc < MaxSrc) ? PeriphSrc : MaxSrc;

  logic [31:0]                     core_map_q;
  logic [LevelW-1:0]               level_mask_q;
  logic [7:0]                      core_q, core_d;
  logic [PERIPH_REGS-1:0][7:0]     flags_q, flags_d;
  logic [PERIPH_REGS-1:0][7:0]     enables_q, enables_d;
  logic [MaxSrc-1:0]               active_q, active_d;
  logic [PERIPH_REGS-1:0][7:0]     level_ro;
  logic                            src_valid;
  logic                            src_was_active;
  logic                            raised;
  logic                            pending;
  logic [7:0]                      rd;
  logic                            bad;

  always_comb begin
    for (int r = 0; r < PERIPH_REGS; r++) begin
      for (int b = 0; b < 8; b++) begin
        if (8 * r + b < LevelW) begin
          level_ro[r][b] = level_mask_q[(8 * r + b) % LevelW];
        end else begin
          level_ro[r][b] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    src_valid      = 32'(item_i.source) < NumSrc;
    src_was_active = 1'b0;
    for (int s = 0; s < MaxSrc; s++) begin
      if (item_i.source == 5'(s)) begin
        src_was_active = active_q[s];
      end
    end
  end

  always_comb begin
    core_d    = core_q;
    flags_d   = flags_q;
    enables_d = enables_q;
    active_d  = active_q;
    rd        = '0;
    bad       = 1'b0;
    raised    = 1'b0;
    unique case (kind_e'(item_i.kind))
      KIND_READ: begin
        bad = 1'b1;
        if (item_i.reg_select == RegCore) begin
          rd  = core_q;
          bad = 1'b0;
        end
        for (int r = 0; r < PERIPH_REGS; r++) begin
          if (32'(item_i.reg_select) == r + 1) begin
            rd  = flags_q[r];
            bad = 1'b0;
          end
          if (32'(item_i.reg_select) == r + 1 + PERIPH_REGS) begin
            rd  = enables_q[r];
            bad = 1'b0;
          end
        end
      end
      KIND_WRITE: begin
        if (item_i.reg_select == RegCore) begin
          core_d = item_i.write_data;
        end
        for (int r = 0; r < PERIPH_REGS; r++) begin
          if (32'(item_i.reg_select) == r + 1) begin
            flags_d[r] = (flags_q[r] & level_ro[r]) | (item_i.write_data & ~level_ro[r]);
          end
          if (32'(item_i.reg_select) == r + 1 + PERIPH_REGS) begin
            enables_d[r] = item_i.write_data;
          end
        end
      end
      KIND_RAISE: begin
        if (src_valid && !src_was_active) begin
          raised = 1'b1;
          for (int s = 0; s < MaxSrc; s++) begin
            if (item_i.source == 5'(s)) begin
              active_d[s] = 1'b1;
            end
          end
          for (int i = 0; i < CoreBits; i++) begin
            if (item_i.source == 5'(i)) begin
              core_d[i] = 1'b1;
            end
          end
          for (int r = 0; r < PERIPH_REGS; r++) begin
            for (int b = 0; b < 8; b++) begin
              if (32'(item_i.source) == CoreBits + 8 * r + b) begin
                flags_d[r][b] = 1'b1;
              end
            end
          end
        end
      end
      KIND_RELEASE: begin
        if (src_valid) begin
          for (int s = 0; s < MaxSrc; s++) begin
            if (item_i.source == 5'(s)) begin
              active_d[s] = 1'b0;
            end
          end
          for (int r = 0; r < PERIPH_REGS; r++) begin
            for (int b = 0; b < 8; b++) begin
              if (32'(item_i.source) == CoreBits + 8 * r + b && level_ro[r][b]) begin
                flags_d[r][b] = 1'b0;
              end
            end
          end
        end
      end
      KIND_SOFT: begin
        core_d    = '0;
        flags_d   = '0;
        enables_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic [3:0] en;
    pending = 1'b0;
    for (int i = 0; i < CoreBits; i++) begin
      en = core_map_q[4 * i +: 4];
      if (!en[3] && core_d[i] && core_d[en[2:0]]) begin
        pending = 1'b1;
      end
    end
    if (core_d[PeieBit]) begin
      for (int r = 0; r < PERIPH_REGS; r++) begin
        if ((flags_d[r] & enables_d[r]) != 8'd0) begin
          pending = 1'b1;
        end
      end
    end
  end

  assign result_o.read_data       = rd & ByteMask;
  assign result_o.bad_address     = bad;
  assign result_o.request_pending = pending;
  assign result_o.interrupt_event = raised && pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_map_q   <= CoreMapReset;
      level_mask_q <= '0;
      core_q       <= '0;
      flags_q      <= '0;
      enables_q    <= '0;
      active_q     <= '0;
    end else begin
      if (cfg_i.we && cfg_i.index == CfgCoreMap) begin
        core_map_q <= cfg_i.data;
      end
      if (cfg_i.we && cfg_i.index == CfgLevelMask) begin
        level_mask_q <= cfg_i.data[LevelW-1:0];
      end
      if (accept_i) begin
        core_q    <= core_d;
        flags_q   <= flags_d;
        enables_q <= enables_d;
        active_q  <= active_d;
      end
    end
  end

endmodule

// ===== hdl/ifec_out_buf.sv =====
// Result register with skid stage of the controller.
module ifec_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ifec_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output ifec_pkg::result_t out_res_o,
  input  logic              out_ready_i
);
  import ifec_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    take;

  assign take        = out_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || take) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

endmodule

// ===== hdl/interrupt_flag_enable_controller_top.sv =====
// Top level of the interrupt flag and enable controller.
// Usage:
//   item_i carries one bus read, bus write, signal raise, signal release or
//   soft reset per item; result_o returns exactly one result item for each.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes the
//   core enable map (index 0) and the level source mask (index 1); write it
//   only while no item is in flight.
// Flow:
//   The register update and the request check finish in the cycle an item is
//   accepted; its result goes to result_o through the result register. One
//   item is accepted per cycle while item_i.ready is high.
// Reset:
//   rst_ni clears all flag, enable and active state; the enable map resets to
//   all-no-source and the level mask to zero. No result is pending.
// Stall:
//   A skid stage behind the result register takes one more item while the
//   receiver holds off; after that item_i.ready stays low until the receiver
//   takes a result, and rises again on the following cycle.
module interrupt_flag_enable_controller_top #(
  parameter int unsigned PERIPH_REGS = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  ifec_item_if.sink_mp             item_i,
  ifec_result_if.source_mp         result_o
);
  import ifec_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res, out_res;
  logic    accept, ready;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign item.kind       = item_i.kind;
  assign item.reg_select = item_i.reg_select;
  assign item.write_data = item_i.write_data;
  assign item.source     = item_i.source;

  assign item_i.ready = ready;
  assign accept       = item_i.valid && ready;

  ifec_core #(
    .PERIPH_REGS(PERIPH_REGS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .accept_i(accept),
    .item_i  (item),
    .result_o(res)
  );

  ifec_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res),
    .ready_o    (ready),
    .out_valid_o(result_o.valid),
    .out_res_o  (out_res),
    .out_ready_i(result_o.ready)
  );

  assign result_o.read_data       = out_res.read_data;
  assign result_o.bad_address     = out_res.bad_address;
  assign result_o.request_pending = out_res.request_pending;
  assign result_o.interrupt_event = out_res.interrupt_event;

endmodule

// ===== sim/interrupt_flag_enable_controller_top_test.sv =====
// Self-checking testbench of the interrupt flag and enable controller top level.
module interrupt_flag_enable_controller_top_test;
  import ifec_pkg::*;

  localparam int PeriphRegs = 2;
  localparam int IdleLimit  = 1000;
  localparam int PhaseItems = 240;
  localparam int NumPhases  = 6;

  localparam logic [2:0] RegFlagLo     = 3'd1;
  localparam logic [2:0] RegFlagHi     = 3'd2;
  localparam logic [2:0] RegEnableLo   = 3'd3;
  localparam logic [2:0] RegEnableHi   = 3'd4;
  localparam logic [2:0] RegInvalidLo  = 3'd5;
  localparam logic [2:0] RegInvalidMid = 3'd6;
  localparam logic [2:0] RegInvalidHi  = 3'd7;
  localparam logic [2:0] KindSpareLo   = 3'd5;
  localparam logic [2:0] KindSpareHi   = 3'd7;
  localparam logic [4:0] SrcTop        = 5'd31;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct {
    bit          is_cfg;
    logic [31:0] map;
    logic [31:0] mask;
    item_t       it;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  ifec_item_if   item_ch ();
  ifec_result_if resp_ch ();

  interrupt_flag_enable_controller_top #(
    .PERIPH_REGS(PeriphRegs)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (resp_ch)
  );

  // Expected controller state
  logic [31:0]        en_map;
  logic [LevelW-1:0]  lvl_mask;
  logic [7:0]         core_ctl;
  logic [7:0]         flag_bytes [PeriphRegs];
  logic [7:0]         enable_bytes [PeriphRegs];
  logic [MaxSrc-1:0]  src_active;

  result_t irq_response_q [$];
  result_t want_res;
  int      fail_cnt;
  int      idle_cycles;
  bit      no_idle;
  int      ready_run;
  int      ready_stall;

  function automatic logic request_level();
    logic [3:0] en;
    for (int i = 0; i < CoreBits; i++) begin
      en = en_map[4*i +: 4];
      if (en < CoreBits && core_ctl[i] && core_ctl[en[2:0]]) return 1'b1;
    end
    if (core_ctl[PeieBit]) begin
      for (int r = 0; r < PeriphRegs; r++) begin
        if ((flag_bytes[r] & enable_bytes[r]) != 8'h00) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t irq_response(input item_t it);
    result_t    res;
    int         sel;
    int         src;
    int         k;
    logic [7:0] ro;
    res = '0;
    sel = int'(it.reg_select);
    src = int'(it.source);
    case (it.kind)
      KIND_READ: begin
        if (sel == RegCore) res.read_data = core_ctl;
        else if (sel <= PeriphRegs) res.read_data = flag_bytes[sel-1];
        else if (sel <= 2*PeriphRegs) res.read_data = enable_bytes[sel-1-PeriphRegs];
        else res.bad_address = 1'b1;
      end
      KIND_WRITE: begin
        if (sel == RegCore) begin
          core_ctl = it.write_data;
        end else if (sel <= PeriphRegs) begin
          ro = lvl_mask[8*(sel-1) +: 8];
          flag_bytes[sel-1] = (flag_bytes[sel-1] & ro) | (it.write_data & ~ro);
        end else if (sel <= 2*PeriphRegs) begin
          enable_bytes[sel-1-PeriphRegs] = it.write_data;
        end
      end
      KIND_RAISE: begin
        if (src < CoreBits + 8*PeriphRegs && !src_active[src]) begin
          if (src < CoreBits) begin
            core_ctl[src] = 1'b1;
          end else begin
            k = src - CoreBits;
            flag_bytes[k/8][k%8] = 1'b1;
          end
          src_active[src] = 1'b1;
          res.interrupt_event = request_level();
        end
      end
      KIND_RELEASE: begin
        if (src < CoreBits + 8*PeriphRegs) begin
          src_active[src] = 1'b0;
          if (src >= CoreBits && lvl_mask[src-CoreBits]) begin
            k = src - CoreBits;
            flag_bytes[k/8][k%8] = 1'b0;
          end
        end
      end
      KIND_SOFT: begin
        core_ctl = '0;
        for (int r = 0; r < PeriphRegs; r++) begin
          flag_bytes[r]   = '0;
          enable_bytes[r] = '0;
        end
      end
      default: ;
    endcase
    res.request_pending = request_level();
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 22) it.kind = KIND_READ;
    else if (r < 48) it.kind = KIND_WRITE;
    else if (r < 72) it.kind = KIND_RAISE;
    else if (r < 94) it.kind = KIND_RELEASE;
    else if (r < 97) it.kind = KIND_SOFT;
    else it.kind = 3'($urandom_range(KindSpareLo, KindSpareHi));
    if ($urandom_range(0, 9) != 0) it.reg_select = 3'($urandom_range(RegCore, RegEnableHi));
    else it.reg_select = 3'($urandom_range(RegInvalidLo, RegInvalidHi));
    it.write_data = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) != 0) it.source = 5'($urandom_range(0, MaxSrc - 1));
    else it.source = 5'($urandom_range(MaxSrc, SrcTop));
    return it;
  endfunction

  function automatic row_t item_row(input logic [2:0] kind, input logic [2:0] sel,
                                    input logic [7:0] wd, input logic [4:0] src);
    row_t row;
    row.is_cfg = 1'b0;
    row.map    = '0;
    row.mask   = '0;
    row.it     = {kind, sel, wd, src};
    row.typed  = 1'b0;
    row.res    = '0;
    return row;
  endfunction

  function automatic row_t item_row_chk(input logic [2:0] kind, input logic [2:0] sel,
                                        input logic [7:0] wd, input logic [4:0] src,
                                        input logic [7:0] rd, input logic bad,
                                        input logic pend, input logic ev);
    row_t row;
    row       = item_row(kind, sel, wd, src);
    row.typed = 1'b1;
    row.res   = {rd, bad, pend, ev};
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [31:0] map, input logic [31:0] mask);
    row_t row;
    row        = item_row(KIND_READ, RegCore, 8'h00, 5'd0);
    row.is_cfg = 1'b1;
    row.map    = map;
    row.mask   = mask;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res,
                           input int gap);
    bit      hit;
    result_t res;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= it.kind;
    item_ch.reg_select <= it.reg_select;
    item_ch.write_data <= it.write_data;
    item_ch.source     <= it.source;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk_i);
      hit = item_ch.valid && item_ch.ready;
      if (hit) begin
        res = irq_response(it);
        irq_response_q.push_back(typed ? typed_res : res);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic hold_items();
    item_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (irq_response_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] map, input logic [31:0] mask_word);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgCoreMap;
    cfg_data_i  <= map;
    @(posedge clk_i);
    cfg_index_i <= CfgLevelMask;
    cfg_data_i  <= mask_word;
    @(posedge clk_i);
    cfg_index_i <= $urandom_range(0, 1) ? CfgSpareA : CfgSpareB;
    cfg_data_i  <= $urandom();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    en_map   = map;
    lvl_mask = mask_word[LevelW-1:0];
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    resp_ch.ready = 1'b0;
    ready_run     = 0;
    ready_stall   = 0;
    forever begin
      @(posedge clk_i);
      if (ready_stall > 0 && !no_idle) begin
        resp_ch.ready <= 1'b0;
        ready_stall--;
      end else begin
        resp_ch.ready <= 1'b1;
        if (ready_run == 0) begin
          ready_run   = $urandom_range(1, 30);
          ready_stall = pick_gap();
        end else begin
          ready_run--;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (resp_ch.valid && resp_ch.ready) begin
      if (irq_response_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time,
                 {resp_ch.read_data, resp_ch.bad_address, resp_ch.request_pending,
                  resp_ch.interrupt_event});
        fail_cnt++;
      end else begin
        want_res = irq_response_q.pop_front();
        check_field("read_data", want_res.read_data, resp_ch.read_data);
        check_field("bad_address", 8'(want_res.bad_address), 8'(resp_ch.bad_address));
        check_field("request_pending", 8'(want_res.request_pending),
                    8'(resp_ch.request_pending));
        check_field("interrupt_event", 8'(want_res.interrupt_event),
                    8'(resp_ch.interrupt_event));
      end
    end
    if ((item_ch.valid && item_ch.ready) || (resp_ch.valid && resp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t        stim_tab [$];
    logic [31:0] phase_map  [NumPhases];
    logic [31:0] phase_mask [NumPhases];

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CfgCoreMap;
    cfg_data_i         = '0;
    item_ch.valid      = 1'b0;
    item_ch.kind       = KIND_READ;
    item_ch.reg_select = RegCore;
    item_ch.write_data = '0;
    item_ch.source     = '0;
    fail_cnt           = 0;
    idle_cycles        = 0;
    no_idle            = 1'b0;

    en_map     = CoreMapReset;
    lvl_mask   = '0;
    core_ctl   = '0;
    src_active = '0;
    for (int r = 0; r < PeriphRegs; r++) begin
      flag_bytes[r]   = '0;
      enable_bytes[r] = '0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    stim_tab.push_back(item_row_chk(KIND_READ, RegCore, 8'h00, 5'd0, 8'h00, 0, 0, 0));
    stim_tab.push_back(item_row_chk(KIND_READ, RegInvalidLo, 8'hFF, SrcTop, 8'h00, 1, 0, 0));
    stim_tab.push_back(item_row_chk(KIND_READ, RegInvalidHi, 8'h00, 5'd0, 8'h00, 1, 0, 0));
    stim_tab.push_back(item_row_chk(KIND_WRITE, RegCore, 8'hFF, 5'd0, 8'h00, 0, 0, 0));
    stim_tab.push_back(item_row_chk(KIND_READ, RegCore, 8'h00, 5'd0, 8'hFF, 0, 0, 0));
    stim_tab.push_back(item_row(KIND_WRITE, RegEnableLo, 8'hFF, 5'd0));
    stim_tab.push_back(item_row(KIND_WRITE, RegEnableHi, 8'hFF, 5'd0));
    stim_tab.push_back(item_row_chk(KIND_RAISE, RegCore, 8'h00, 5'd8, 8'h00, 0, 1, 1));
    stim_tab.push_back(item_row_chk(KIND_RAISE, RegCore, 8'h00, 5'd8, 8'h00, 0, 1, 0));
    stim_tab.push_back(item_row(KIND_RELEASE, RegCore, 8'h00, 5'd8));
    stim_tab.push_back(item_row(KIND_RAISE, RegCore, 8'h00, 5'd23));
    stim_tab.push_back(item_row(KIND_RAISE, RegCore, 8'h00, SrcTop));
    stim_tab.push_back(item_row(KIND_RELEASE, RegCore, 8'h00, 5'd30));
    stim_tab.push_back(item_row(KIND_WRITE, RegFlagLo, 8'h00, 5'd0));
    stim_tab.push_back(item_row(KIND_WRITE, RegFlagHi, 8'hFF, 5'd0));
    stim_tab.push_back(item_row(KIND_READ, RegFlagHi, 8'h00, 5'd0));
    stim_tab.push_back(item_row(KIND_WRITE, RegInvalidMid, 8'hAA, 5'd0));
    stim_tab.push_back(item_row(KindSpareHi, RegInvalidHi, 8'hFF, SrcTop));
    stim_tab.push_back(item_row_chk(KIND_SOFT, RegCore, 8'h00, 5'd0, 8'h00, 0, 0, 0));
    stim_tab.push_back(item_row_chk(KIND_READ, RegEnableLo, 8'h00, 5'd0, 8'h00, 0, 0, 0));
    stim_tab.push_back(item_row(KIND_RAISE, RegCore, 8'h00, 5'd0));
    stim_tab.push_back(item_row(KIND_RELEASE, RegCore, 8'h00, 5'd0));
    stim_tab.push_back(cfg_row(32'h7654_3210, 32'hABCD_00F0));
    stim_tab.push_back(item_row_chk(KIND_SOFT, RegCore, 8'h00, 5'd0, 8'h00, 0, 0, 0));
    stim_tab.push_back(item_row(KIND_RAISE, RegCore, 8'h00, 5'd12));
    stim_tab.push_back(item_row(KIND_WRITE, RegFlagLo, 8'h00, 5'd0));
    stim_tab.push_back(item_row(KIND_READ, RegFlagLo, 8'h00, 5'd0));
    stim_tab.push_back(item_row(KIND_RELEASE, RegCore, 8'h00, 5'd12));
    stim_tab.push_back(item_row(KIND_READ, RegFlagLo, 8'h00, 5'd0));
    stim_tab.push_back(item_row_chk(KIND_RAISE, RegCore, 8'h00, 5'd3, 8'h00, 0, 1, 1));

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        hold_items();
        set_config(stim_tab[i].map, stim_tab[i].mask);
      end else begin
        send_item(stim_tab[i].it, stim_tab[i].typed, stim_tab[i].res, pick_gap());
      end
    end
    hold_items();

    phase_map[0]  = 32'h0000_0000;
    phase_mask[0] = 32'h0000_FFFF;
    phase_map[1]  = 32'hFFFF_FFFF;
    phase_mask[1] = 32'hFFFF_0000;
    phase_map[2]  = 32'h7654_3210;
    phase_mask[2] = $urandom();
    for (int p = 3; p < NumPhases; p++) begin
      phase_map[p]  = $urandom();
      phase_mask[p] = $urandom();
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_config(phase_map[p], phase_mask[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        no_idle = (n < 50);
        send_item(random_item(), 1'b0, '0, no_idle ? 0 : pick_gap());
      end
      hold_items();
      no_idle = 1'b0;
    end

    while (irq_response_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
